/* sv/rau_pkg.sv */
package rau_pkg;
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   localparam logic [63:0] MAX_PART = 64'd2147483647;

   typedef struct packed {
      logic [1:0]  operation;
      logic signed [31:0] left_numerator;
      logic signed [31:0] left_denominator;
      logic signed [31:0] right_numerator;
      logic signed [31:0] right_denominator;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] result_numerator;
      logic [30:0] result_denominator;
      logic [1:0]  status;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request word
      logic mul1;      // first cross products
      logic mul2;      // third product, combine
      logic gcd_start;
      logic div_start; // divide both parts by gcd
      logic finish;    // build response word
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic bad_input;
      logic zero_num;
      logic gcd_done;
      logic div_done;
   } sts_type;
endpackage

/* sv/rau_if.sv */
interface rau_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* sv/rau_ctrl.sv */
module rau_ctrl
   import rau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL1  = 3'd1;
   localparam logic [2:0] S_MUL2  = 3'd2;
   localparam logic [2:0] S_GCD   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;
   localparam logic [2:0] S_DWAIT = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       fin;

   assign rsp_valid = valid_ff;
   assign req_ready = (state_ff == S_IDLE) && (!valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      fin = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_OUT;
            if (!sts.bad_input) begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (sts.zero_num) begin
               state_in = S_OUT;
            end else begin
               cmd.gcd_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // gcd_start launched the gcd; wait, then divide
            if (sts.gcd_done) begin
               cmd.div_start = 1'b1;
               state_in = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (sts.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               fin = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) valid_in = 1'b0;
      if (fin) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule

/* sv/rau_dp.sv */
module rau_dp
   import rau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  cmd_type      cmd,
   output sts_type      sts,
   output rsp_word_type rsp_word
);
   req_word_type w_ff;
   logic [31:0]  ma, mb, mc, md;
   logic         sa, sb, sc, sd;
   logic [63:0]  p1_ff, p2_ff, nm_ff, dm_ff;
   logic         p1n_ff, p2n_ff, nn_ff, dn_ff, bad_ff;
   logic [63:0]  x_ff, y_ff;          // gcd operands
   logic         gbusy_ff, gdone_ff;
   logic [63:0]  qn_ff, rn_ff, qd_ff, rd_ff, g_ff;
   logic [6:0]   cnt_ff;
   logic         dbusy_ff, ddone_ff;
   rsp_word_type out_ff;
   logic [63:0]  x_sh, x_red;
   logic [64:0]  trn, trd;
   logic [6:0]   zsh_ff;
   logic [63:0]  sum_m;
   logic         sum_n, t2n;

   assign sa = w_ff.left_numerator[31];
   assign sb = w_ff.left_denominator[31];
   assign sc = w_ff.right_numerator[31];
   assign sd = w_ff.right_denominator[31];
   assign ma = sa ? 32'(-w_ff.left_numerator) : w_ff.left_numerator;
   assign mb = sb ? 32'(-w_ff.left_denominator) : w_ff.left_denominator;
   assign mc = sc ? 32'(-w_ff.right_numerator) : w_ff.right_numerator;
   assign md = sd ? 32'(-w_ff.right_denominator) : w_ff.right_denominator;

   assign sts.bad_input = bad_ff;
   assign sts.zero_num  = (nm_ff == 64'd0);
   assign sts.gcd_done  = gdone_ff;
   assign sts.div_done  = ddone_ff;
   assign rsp_word = out_ff;

   assign t2n = (w_ff.operation == OP_SUB) ? ~p2n_ff : p2n_ff;
   always_comb begin
      if (p1n_ff == t2n) begin
         sum_m = p1_ff + p2_ff; sum_n = p1n_ff;
      end else if (p1_ff >= p2_ff) begin
         sum_m = p1_ff - p2_ff; sum_n = p1n_ff;
      end else begin
         sum_m = p2_ff - p1_ff; sum_n = t2n;
      end
   end

   // binary-free Euclid step: one conditional subtract of y shifted, per cycle
   always_comb begin
      x_sh = y_ff << zsh_ff[5:0];
      x_red = (x_ff >= x_sh) ? x_ff - x_sh : x_ff;
   end
   assign trn = {rn_ff, qn_ff[63]} - {1'b0, g_ff};
   assign trd = {rd_ff, qd_ff[63]} - {1'b0, g_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) w_ff <= req_word;
      if (cmd.mul1) begin
         bad_ff <= (mb == 0) || (md == 0) ||
                   (w_ff.operation == OP_DIV && mc == 0);
         unique case (w_ff.operation)
            OP_MUL: begin
               p1_ff <= 64'(ma) * 64'(mc); p1n_ff <= sa ^ sc;
            end
            default: begin
               p1_ff <= 64'(ma) * 64'(md); p1n_ff <= sa ^ sd;
            end
         endcase
         unique case (w_ff.operation)
            OP_DIV: begin
               p2_ff <= 64'(mb) * 64'(mc); p2n_ff <= sb ^ sc;
            end
            default: begin
               p2_ff <= 64'(mb) * 64'(mc); p2n_ff <= sb ^ sc;
            end
         endcase
      end
      if (cmd.mul2) begin
         unique case (w_ff.operation)
            OP_ADD, OP_SUB: begin
               nm_ff <= sum_m; nn_ff <= sum_n;
               dm_ff <= 64'(mb) * 64'(md); dn_ff <= sb ^ sd;
            end
            OP_MUL: begin
               nm_ff <= p1_ff; nn_ff <= p1n_ff;
               dm_ff <= 64'(mb) * 64'(md); dn_ff <= sb ^ sd;
            end
            default: begin
               nm_ff <= p1_ff; nn_ff <= p1n_ff;
               dm_ff <= p2_ff; dn_ff <= p2n_ff;
            end
         endcase
      end
   end

   // gcd: x mod y by shift-subtract; shift counts down from the top
   always_ff @(posedge clock) begin
      if (reset) begin
         gbusy_ff <= 1'b0; gdone_ff <= 1'b0;
      end else if (cmd.gcd_start) begin
         x_ff <= nm_ff; y_ff <= dm_ff; zsh_ff <= 7'd63;
         gbusy_ff <= 1'b1; gdone_ff <= 1'b0;
      end else if (gbusy_ff) begin
         if (y_ff == 64'd0) begin
            g_ff <= x_ff; gbusy_ff <= 1'b0; gdone_ff <= 1'b1;
         end else if (zsh_ff[6] || (y_ff << zsh_ff[5:0]) >> zsh_ff[5:0] != y_ff) begin
            if (zsh_ff[6]) begin
               x_ff <= y_ff; y_ff <= x_ff; zsh_ff <= 7'd63;
            end else begin
               zsh_ff <= zsh_ff - 7'd1;
            end
         end else begin
            x_ff <= x_red; zsh_ff <= zsh_ff - 7'd1;
         end
      end else begin
         gdone_ff <= 1'b0;
      end
   end

   // two restoring dividers sharing one count
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0; ddone_ff <= 1'b0;
      end else if (cmd.div_start) begin
         qn_ff <= nm_ff; rn_ff <= '0; qd_ff <= dm_ff; rd_ff <= '0;
         cnt_ff <= 7'd0; dbusy_ff <= 1'b1; ddone_ff <= 1'b0;
      end else if (dbusy_ff) begin
         if (!trn[64]) begin
            rn_ff <= trn[63:0]; qn_ff <= {qn_ff[62:0], 1'b1};
         end else begin
            rn_ff <= {rn_ff[62:0], qn_ff[63]}; qn_ff <= {qn_ff[62:0], 1'b0};
         end
         if (!trd[64]) begin
            rd_ff <= trd[63:0]; qd_ff <= {qd_ff[62:0], 1'b1};
         end else begin
            rd_ff <= {rd_ff[62:0], qd_ff[63]}; qd_ff <= {qd_ff[62:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            dbusy_ff <= 1'b0; ddone_ff <= 1'b1;
         end
      end else begin
         ddone_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (bad_ff) begin
            out_ff <= '{32'sd0, 31'd0, ST_ZERO};
         end else if (nm_ff == 64'd0) begin
            out_ff <= '{32'sd0, 31'd1, ST_OK};
         end else if (qn_ff > MAX_PART || qd_ff > MAX_PART) begin
            out_ff <= '{32'sd0, 31'd0, ST_OVF};
         end else begin
            out_ff.result_numerator <= (nn_ff != dn_ff) ? -$signed(qn_ff[31:0])
                                                        : $signed(qn_ff[31:0]);
            out_ff.result_denominator <= qd_ff[30:0];
            out_ff.status <= ST_OK;
         end
      end
   end
endmodule

/* sv/rational_arithmetic_unit_core.sv */
// From request accept to response valid: a zero denominator or divisor goes from the
// multiply states straight to output, a zero result leaves at the gcd state without running
// it, and otherwise the gcd runs shift-subtract remainder steps, each ending in a swap, then the dividers.
// Throughput: one word at a time; a request is taken only in idle, once the
// response register is empty or being read. Reset is synchronous, active high,
// clears control only.
module rational_arithmetic_unit_core
   import rau_pkg::*;
(
   input logic clock,
   input logic reset,
   rau_if.sink   req,
   rau_if.source rsp
);
   cmd_type cmd;
   sts_type sts;

   rau_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .sts, .cmd
   );
   rau_dp u_dp (
      .clock, .reset, .req_word(req.data), .cmd, .sts, .rsp_word(rsp.data)
   );
endmodule

/* sv/rau_checker.sv */
module rau_checker
   import rau_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_word_type rsp_data
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_OVF) else $error("bad status");
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.result_denominator == 0)
      else $error("error word not cleared");
   a_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_OK |-> rsp_data.result_denominator != 0)
      else $error("zero denominator on ok");
   // one word in flight: no request is taken right after another
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");
endmodule

bind rational_arithmetic_unit_core rau_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

/* tb/sv/rational_arithmetic_unit_checker.sv */
module rational_arithmetic_unit_checker
   import rau_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  rsp_word_type rsp_data,
   output int           failures,
   output int           pending
);
   rsp_word_type expected_fractions[$];

   function automatic logic [63:0] abs64(logic signed [63:0] v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] gcd64(logic [63:0] p, logic [63:0] q);
      logic [63:0] r;
      while (q != 0) begin
         r = p % q;
         p = q;
         q = r;
      end
      return p;
   endfunction

   function automatic rsp_word_type reduce_fraction(req_word_type w);
      logic signed [63:0] a, b, c, d;
      logic nneg, dneg, t1n, t2n;
      logic [63:0] nmag, dmag, t1m, t2m, g, rn, rd;
      rsp_word_type o;
      a = w.left_numerator;
      b = w.left_denominator;
      c = w.right_numerator;
      d = w.right_denominator;
      o = '0;
      o.status = ST_OK;
      if (b == 0 || d == 0 || (w.operation == OP_DIV && c == 0)) begin
         o.status = ST_ZERO;
         return o;
      end
      dneg = (b < 0) != (d < 0);
      dmag = abs64(b) * abs64(d);
      case (w.operation)
         OP_ADD, OP_SUB: begin
            t1m = abs64(a) * abs64(d);
            t1n = t1m != 0 && ((a < 0) != (d < 0));
            t2m = abs64(b) * abs64(c);
            t2n = t2m != 0 && ((b < 0) != (c < 0));
            if (w.operation == OP_SUB && t2m != 0) t2n = !t2n;
            // sign-magnitude sum, can reach 2^63
            if (t1n == t2n) begin
               nmag = t1m + t2m;
               nneg = t1n;
            end else if (t1m >= t2m) begin
               nmag = t1m - t2m;
               nneg = t1n;
            end else begin
               nmag = t2m - t1m;
               nneg = t2n;
            end
         end
         OP_MUL: begin
            nmag = abs64(a) * abs64(c);
            nneg = (a < 0) != (c < 0);
         end
         default: begin
            nmag = abs64(a) * abs64(d);
            nneg = (a < 0) != (d < 0);
            dmag = abs64(b) * abs64(c);
            dneg = (b < 0) != (c < 0);
         end
      endcase
      if (nmag == 0) begin
         o.result_denominator = 31'd1;
         return o;
      end
      g = gcd64(nmag, dmag);
      rn = nmag / g;
      rd = dmag / g;
      if (rn > MAX_PART || rd > MAX_PART) begin
         o.status = ST_OVF;
         return o;
      end
      o.result_numerator = (nneg != dneg) ? -$signed(rn[31:0]) : $signed(rn[31:0]);
      o.result_denominator = rd[30:0];
      return o;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      failures++;
      if (failures <= 40)
         $display("mismatch %s: got %0d (0x%h) want %0d (0x%h)",
                  field, $signed(got), got, $signed(want), want);
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         failures = 0;
      end else begin
         if (req_valid && req_ready)
            expected_fractions.push_back(reduce_fraction(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_fractions.size() == 0) begin
               report("unexpected word", 32'(rsp_data), 32'd0);
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_data.result_numerator !== want.result_numerator)
                  report("numerator", rsp_data.result_numerator, want.result_numerator);
               if (rsp_data.result_denominator !== want.result_denominator)
                  report("denominator", 32'(rsp_data.result_denominator),
                         32'(want.result_denominator));
               if (rsp_data.status !== want.status)
                  report("status", 32'(rsp_data.status), 32'(want.status));
            end
         end
      end
      pending = expected_fractions.size();
   end
endmodule

/* tb/sv/rational_arithmetic_unit_core_tb.sv */
module rational_arithmetic_unit_core_tb;
   import rau_pkg::*;

   localparam int STALL_LIMIT = 200000;
   localparam logic signed [31:0] MAX_S = 32'sh7FFFFFFF;
   localparam logic signed [31:0] MIN_S = 32'sh80000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic idle_on = 1'b1;
   int   failures, pending, quiet_cycles;

   rau_if #(.word_type(req_word_type)) req_ch ();
   rau_if #(.word_type(rsp_word_type)) rsp_ch ();

   rational_arithmetic_unit_core uut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   rational_arithmetic_unit_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
      .failures(failures), .pending(pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_ch.ready <= idle_on ? ($urandom_range(99) >= 22) : 1'b1;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic signed [31:0] pick_part();
      case ($urandom_range(9))
         0: return 32'sd0;
         1: return $urandom_range(1) ? MAX_S : MIN_S;
         2: return $urandom_range(1) ? 32'sd1 : -32'sd1;
         3, 4, 5: return $signed(32'($urandom_range(2000))) - 32'sd1000;
         6: return $signed(32'($urandom_range(200000))) - 32'sd100000;
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic send_fraction(logic [1:0] op, logic signed [31:0] a,
                                logic signed [31:0] b, logic signed [31:0] c,
                                logic signed [31:0] d);
      req_word_type w;
      w.operation = op;
      w.left_numerator = a;
      w.left_denominator = b;
      w.right_numerator = c;
      w.right_denominator = d;
      if (idle_on && $urandom_range(99) < 22) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= w;
      // ready is checked mid-cycle, away from the edge
      do @(negedge clock); while (!req_ch.ready);
      @(posedge clock);
   endtask

   initial begin
      logic [1:0] op;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_fraction(OP_ADD, 1, 2, 1, 3);
      send_fraction(OP_SUB, 1, 2, 1, 3);
      send_fraction(OP_MUL, -3, 4, 2, 9);
      send_fraction(OP_DIV, 3, -4, -2, 9);
      send_fraction(OP_ADD, 5, 0, 1, 3);      // zero left denominator
      send_fraction(OP_MUL, 5, 7, 1, 0);      // zero right denominator
      send_fraction(OP_DIV, 5, 7, 0, 3);      // divide by zero fraction
      send_fraction(OP_SUB, 1, 2, 1, 2);      // zero result
      send_fraction(OP_MUL, 0, -5, 7, 3);
      send_fraction(OP_ADD, MAX_S, 1, MAX_S, 1);  // overflow
      send_fraction(OP_MUL, MIN_S, 1, 1, 1);  // -2^31 counts as overflow
      send_fraction(OP_ADD, MIN_S, MIN_S, MIN_S, MIN_S); // wide sum
      send_fraction(OP_SUB, MIN_S, MIN_S, MAX_S, MIN_S);
      send_fraction(OP_ADD, MIN_S, -1, MIN_S, 1);
      send_fraction(OP_DIV, MAX_S, MIN_S, MIN_S, MAX_S);
      send_fraction(OP_MUL, MAX_S, MAX_S, MAX_S, MAX_S);
      send_fraction(OP_DIV, -1, -1, -1, -1);
      send_fraction(OP_SUB, MAX_S, MIN_S, MIN_S, MAX_S);
      send_fraction(OP_DIV, 32'sh55555555, 32'shAAAAAAAA, 32'sh2AAAAAAA, 32'sh7FFF0001);
      send_fraction(OP_MUL, 32'shFFFFFFFF, 32'h7FFFFFFF, 32'h0000FFFF, 32'shFFFF0000);

      for (int i = 0; i < 1330; i++) begin
         idle_on = !(i >= 550 && i < 850);
         op = 2'($urandom_range(3));
         send_fraction(op, pick_part(), pick_part(), pick_part(), pick_part());
      end
      req_ch.valid <= 1'b0;
      idle_on = 1'b1;

      do @(negedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
